// ===== rtl/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the flow record cache.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_WIDTH   = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] DEFAULT_IDLE  = 32'd10;
    localparam logic [7:0]  SUM_INDICATOR = 8'hFF;

    localparam int S_TDATA_W = 448;
    localparam int M_TDATA_W = 544;

    typedef enum logic [2:0] {
        KIND_INSERTED = 3'd0,
        KIND_UPDATED  = 3'd1,
        KIND_DROPPED  = 3'd2,
        KIND_EXPIRED  = 3'd3,
        KIND_DONE     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PKT_DONE,
        ST_SWEEP,
        ST_SWEEP_OUT,
        ST_FINAL,
        ST_OUT_WAIT
    } state_t;

    // packet fields as held in the datapath
    typedef struct packed {
        logic [31:0]          now;
        logic [KEY_WIDTH-1:0] key;
        logic [7:0]           ind;
        logic [19:0]          label;
        logic [63:0]          src_hi;
        logic [63:0]          src_lo;
        logic [63:0]          dst_hi;
        logic [63:0]          dst_lo;
        logic [63:0]          value;
    } pkt_t;

    // commands from the controller
    typedef struct packed {
        logic             load;      // capture input word, clear search state
        logic [IDX_W-1:0] idx;       // entry under visit
        logic             visit;     // record match or free slot at idx
        logic             pkt_out;   // build packet result and write table
        logic             exp_out;   // export entry idx and free it
        logic             done_out;  // build sweep done marker
    } cmd_t;

    // status to the controller
    typedef struct packed {
        logic hit;       // current entry matches the packet
        logic expired;   // current entry is idle too long
        logic found;     // a match has been recorded
    } sts_t;

endpackage

// ===== rtl/frc_ctrl.sv =====
// ----------------------------------------------------------------------------
// frc_ctrl
// Controller: walks the table once per item and sequences the result words.
// ----------------------------------------------------------------------------
module frc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_op,
    output logic           m_tvalid,
    input  logic           m_tready,
    output frc_pkg::cmd_t  cmd,
    input  frc_pkg::sts_t  sts
);
    import frc_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_idx;

    assign last_idx = (idx_reg == IDX_W'(TABLE_DEPTH - 1));

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next   = '0;
                    state_next = s_op ? ST_SWEEP : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (sts.hit || last_idx) begin
                    state_next = ST_PKT_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PKT_DONE: state_next = ST_OUT_WAIT;
            ST_SWEEP: begin
                if (sts.expired) begin
                    state_next = ST_SWEEP_OUT;
                end else if (last_idx) begin
                    state_next = ST_FINAL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SWEEP_OUT: begin
                if (m_tready) begin
                    if (last_idx) begin
                        state_next = ST_FINAL;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_FINAL: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        cmd          = '0;
        cmd.idx      = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SEARCH:    cmd.visit = 1'b1;
            ST_PKT_DONE:  cmd.pkt_out = 1'b1;
            ST_SWEEP:     cmd.exp_out = sts.expired;
            ST_SWEEP_OUT: m_tvalid = 1'b1;
            ST_FINAL:     cmd.done_out = 1'b1;
            ST_OUT_WAIT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== rtl/frc_dpath.sv =====
// ----------------------------------------------------------------------------
// frc_dpath
// Datapath: record table, packet holding register, result register.
// ----------------------------------------------------------------------------
module frc_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [frc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              cfg_wr_en,
    input  logic [31:0]                       cfg_wr_data,
    output logic [frc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [2:0]                        m_tuser,
    input  frc_pkg::cmd_t                     cmd,
    output frc_pkg::sts_t                     sts
);
    import frc_pkg::*;

    logic [31:0]          idle_reg;
    pkt_t                 pkt_reg;
    logic                 found_reg, free_ok_reg;
    logic [IDX_W-1:0]     hit_idx_reg, free_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [KEY_WIDTH-1:0] t_key    [TABLE_DEPTH];
    logic [7:0]           t_ind    [TABLE_DEPTH];
    logic [19:0]          t_label  [TABLE_DEPTH];
    logic [63:0]          t_src_hi [TABLE_DEPTH];
    logic [63:0]          t_src_lo [TABLE_DEPTH];
    logic [63:0]          t_dst_hi [TABLE_DEPTH];
    logic [63:0]          t_dst_lo [TABLE_DEPTH];
    logic [63:0]          t_value  [TABLE_DEPTH];
    logic [63:0]          t_pkts   [TABLE_DEPTH];
    logic [31:0]          t_start  [TABLE_DEPTH];
    logic [31:0]          t_end    [TABLE_DEPTH];

    logic [M_TDATA_W-1:0] out_reg;
    logic [2:0]           kind_reg;
    logic [IDX_W-1:0]     wi;
    logic [31:0]          age;

    // status from the entry under visit
    assign age         = pkt_reg.now - t_end[cmd.idx];
    assign sts.hit     = valid_reg[cmd.idx] && t_key[cmd.idx] == pkt_reg.key
                         && t_ind[cmd.idx] == pkt_reg.ind;
    assign sts.expired = valid_reg[cmd.idx] && (age > idle_reg);
    assign sts.found   = found_reg;
    assign wi          = found_reg ? hit_idx_reg : free_idx_reg;

    // idle limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) idle_reg <= DEFAULT_IDLE;
        else if (cfg_wr_en) idle_reg <= cfg_wr_data;
    end

    // search state and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            if (cmd.visit) begin
                if (sts.hit) begin
                    found_reg <= 1'b1;
                end else if (!valid_reg[cmd.idx] && !free_ok_reg) begin
                    free_ok_reg <= 1'b1;
                end
            end
            if (cmd.pkt_out && !found_reg && free_ok_reg) valid_reg[wi] <= 1'b1;
            if (cmd.exp_out) valid_reg[cmd.idx] <= 1'b0;
        end
    end

    // payload registers and table writes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pkt_reg.now    <= s_tdata[31:0];
            pkt_reg.key    <= s_tdata[32 +: KEY_WIDTH];
            pkt_reg.ind    <= s_tdata[103:96];
            pkt_reg.label  <= s_tdata[123:104];
            pkt_reg.src_hi <= s_tdata[187:124];
            pkt_reg.src_lo <= s_tdata[251:188];
            pkt_reg.dst_hi <= s_tdata[315:252];
            pkt_reg.dst_lo <= s_tdata[379:316];
            pkt_reg.value  <= s_tdata[443:380];
        end
        if (cmd.visit) begin
            if (sts.hit) hit_idx_reg <= cmd.idx;
            else if (!valid_reg[cmd.idx] && !free_ok_reg) free_idx_reg <= cmd.idx;
        end
        if (cmd.pkt_out) begin
            if (found_reg) begin
                t_value[wi] <= (pkt_reg.ind == SUM_INDICATOR) ?
                               t_value[wi] + pkt_reg.value : 64'd0;
                t_pkts[wi]  <= t_pkts[wi] + 64'd1;
                t_end[wi]   <= pkt_reg.now;
                kind_reg    <= KIND_UPDATED;
                out_reg     <= {4'd0, pkt_reg.now, t_start[wi], t_pkts[wi] + 64'd1,
                                (pkt_reg.ind == SUM_INDICATOR) ?
                                t_value[wi] + pkt_reg.value : 64'd0,
                                t_dst_lo[wi], t_dst_hi[wi], t_src_lo[wi],
                                t_src_hi[wi], t_label[wi], t_ind[wi],
                                64'(t_key[wi])};
            end else begin
                if (free_ok_reg) begin
                    t_key[wi]    <= pkt_reg.key;
                    t_ind[wi]    <= pkt_reg.ind;
                    t_label[wi]  <= pkt_reg.label;
                    t_src_hi[wi] <= pkt_reg.src_hi;
                    t_src_lo[wi] <= pkt_reg.src_lo;
                    t_dst_hi[wi] <= pkt_reg.dst_hi;
                    t_dst_lo[wi] <= pkt_reg.dst_lo;
                    t_value[wi]  <= pkt_reg.value;
                    t_pkts[wi]   <= 64'd1;
                    t_start[wi]  <= pkt_reg.now;
                    t_end[wi]    <= pkt_reg.now;
                end
                kind_reg <= free_ok_reg ? KIND_INSERTED : KIND_DROPPED;
                out_reg  <= {4'd0, pkt_reg.now, pkt_reg.now, 64'd1, pkt_reg.value,
                             pkt_reg.dst_lo, pkt_reg.dst_hi, pkt_reg.src_lo,
                             pkt_reg.src_hi, pkt_reg.label, pkt_reg.ind,
                             64'(pkt_reg.key)};
            end
        end
        if (cmd.exp_out) begin
            kind_reg <= KIND_EXPIRED;
            out_reg  <= {4'd0, t_end[cmd.idx], t_start[cmd.idx], t_pkts[cmd.idx],
                         t_value[cmd.idx], t_dst_lo[cmd.idx], t_dst_hi[cmd.idx],
                         t_src_lo[cmd.idx], t_src_hi[cmd.idx], t_label[cmd.idx],
                         t_ind[cmd.idx], 64'(t_key[cmd.idx])};
        end
        if (cmd.done_out) begin
            kind_reg <= KIND_DONE;
            out_reg  <= '0;
        end
    end

    assign m_tdata = out_reg;
    assign m_tuser = kind_reg;

endmodule

// ===== rtl/flow_record_cache_with_idle_export.sv =====
// ----------------------------------------------------------------------------
// flow_record_cache_with_idle_export
// Flow record cache keyed on indicator and flow key, with idle export sweep.
// ----------------------------------------------------------------------------
// A packet word is taken while the cache is idle and then walks the 32 entries
// one per cycle until it hits or reaches the last entry; its result is then
// built and delivered. A sweep word visits every entry in index order, one per
// cycle while no exported record waits on the output, and each expired entry
// is exported as a record before the walk goes on; the done marker comes at
// the end. A held-off output holds each result word until it is taken.
// One word is in work at a time.
module flow_record_cache_with_idle_export (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now, flow_key, indicator_id, flow_label, src_addr_hi, src_addr_lo,
    // dst_addr_hi, dst_addr_lo, indicator_value, zero fill
    input  logic [447:0] s_tdata,
    // op
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rec_key, rec_indicator, rec_label, rec_src_hi, rec_src_lo, rec_dst_hi,
    // rec_dst_lo, rec_value, rec_packets, rec_start, rec_end, zero fill
    output logic [543:0] m_tdata,
    // kind
    output logic [2:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);
    import frc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // table and result
    frc_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== bench/flow_record_cache_with_idle_export_tb.sv =====
// ----------------------------------------------------------------------------
// flow_record_cache_with_idle_export_tb
// Self-checking bench for the flow record cache with idle export.
// ----------------------------------------------------------------------------
// Packet and sweep words are driven on the input stream. A cycle-free model of
// the table predicts every result word, and each result taken from the output
// stream is checked against the oldest prediction. Both sides idle at random,
// the output is held off for a long stretch so that the cache stalls its
// input, and the idle limit is rewritten between phases.
module flow_record_cache_with_idle_export_tb;
    import frc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 80;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] key;
        logic [7:0]  ind;
        logic [19:0] label;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [63:0] value;
        logic [63:0] packets;
        logic [31:0] start;
        logic [31:0] last;
    } flow_rec_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [447:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [543:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;

    // model of the cache
    flow_rec_t   cache_rec[TABLE_DEPTH];
    bit          cache_used[TABLE_DEPTH];
    logic [31:0] idle_limit;
    flow_rec_t   pending_q[$];

    int  errors;
    int  quiet_cycles;
    int  holdoff_left;
    int  rx_gap;
    bit  idling_on;
    logic [31:0] clock_now;

    logic [63:0] pool_key[40];
    logic [7:0]  pool_ind[40];

    flow_record_cache_with_idle_export dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // work out the result words of one accepted input word
    task automatic predict_cache(input bit op, input flow_rec_t pkt);
        flow_rec_t r;
        int        free_slot;
        if (op) begin
            for (int e = 0; e < TABLE_DEPTH; e++) begin
                if (cache_used[e] && (pkt.start - cache_rec[e].last) > idle_limit) begin
                    r = cache_rec[e];
                    r.kind = KIND_EXPIRED;
                    pending_q.push_back(r);
                    cache_used[e] = 1'b0;
                end
            end
            r = '0;
            r.kind = KIND_DONE;
            pending_q.push_back(r);
            return;
        end
        free_slot = -1;
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            if (cache_used[e]) begin
                if (cache_rec[e].key == pkt.key && cache_rec[e].ind == pkt.ind) begin
                    if (pkt.ind == SUM_INDICATOR)
                        cache_rec[e].value = cache_rec[e].value + pkt.value;
                    else
                        cache_rec[e].value = '0;
                    cache_rec[e].packets = cache_rec[e].packets + 64'd1;
                    cache_rec[e].last = pkt.start;
                    r = cache_rec[e];
                    r.kind = KIND_UPDATED;
                    pending_q.push_back(r);
                    return;
                end
            end else if (free_slot < 0) begin
                free_slot = e;
            end
        end
        r = pkt;
        r.packets = 64'd1;
        r.last = pkt.start;
        if (free_slot < 0) begin
            r.kind = KIND_DROPPED;
        end else begin
            r.kind = KIND_INSERTED;
            cache_rec[free_slot] = r;
            cache_used[free_slot] = 1'b1;
        end
        pending_q.push_back(r);
    endtask

    // send one word; pkt.start carries the current time
    task automatic send_word(input bit op, input flow_rec_t pkt);
        int gap;
        gap = idling_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata = {4'd0, pkt.value, pkt.dst_lo, pkt.dst_hi, pkt.src_lo, pkt.src_hi,
                   pkt.label, pkt.ind, pkt.key, pkt.start};
        s_tuser = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_cache(op, pkt);
    endtask

    task automatic send_packet(input logic [63:0] key, input logic [7:0] ind,
                               input logic [63:0] value);
        flow_rec_t p;
        p = '0;
        p.key    = key;
        p.ind    = ind;
        p.label  = 20'($urandom);
        p.src_hi = {$urandom, $urandom};
        p.src_lo = {$urandom, $urandom};
        p.dst_hi = {$urandom, $urandom};
        p.dst_lo = {$urandom, $urandom};
        p.value  = value;
        p.start  = clock_now;
        send_word(1'b0, p);
    endtask

    task automatic send_sweep();
        flow_rec_t p;
        p = '0;
        p.start = clock_now;
        // unused fields carry noise, the cache must ignore them
        p.key = {$urandom, $urandom};
        p.value = {$urandom, $urandom};
        send_word(1'b1, p);
    endtask

    // stop offering and wait until every predicted word has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_idle_limit(input logic [31:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        idle_limit = v;
    endtask

    // field extremes, summing wrap, clearing indicator, time wrap
    task automatic test_basic_records();
        flow_rec_t p;
        clock_now = 32'hFFFF_FFFE;
        p = '0;
        p.start = clock_now;
        send_word(1'b0, p);
        p = '1;
        send_word(1'b0, p);
        send_packet('1, SUM_INDICATOR, 64'd1);
        send_packet(64'h0, 8'h00, '1);
        send_packet(64'h0, 8'h00, 64'd5);
        clock_now = 32'd3;
        send_packet(64'h1234, SUM_INDICATOR, 64'hFFFF_FFFF_FFFF_FFF0);
        send_packet(64'h1234, SUM_INDICATOR, 64'h20);
        send_packet(64'h1234, 8'h7E, 64'h99);
        send_sweep();
        clock_now = 32'd20;
        send_sweep();
        send_sweep();
    endtask

    // fill every entry, then the packets beyond it are dropped
    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_packet({$urandom, $urandom}, 8'($urandom), {$urandom, $urandom});
        send_packet({$urandom, $urandom}, SUM_INDICATOR, '1);
        clock_now = clock_now + 32'd100;
        send_sweep();
    endtask

    // idle limit boundaries, including the reset value
    task automatic test_idle_limit();
        send_packet(64'hA, 8'h1, 64'd1);
        clock_now = clock_now + 32'd10;
        send_sweep();
        clock_now = clock_now + 32'd1;
        send_sweep();
        write_idle_limit(32'd0);
        send_packet(64'hB, 8'h2, 64'd2);
        send_sweep();
        clock_now = clock_now + 32'd1;
        send_sweep();
        write_idle_limit(32'hFFFF_FFFF);
        send_packet(64'hC, 8'h3, 64'd3);
        clock_now = clock_now - 32'd1;
        send_sweep();
        write_idle_limit(32'hFFFF_FFFE);
        send_sweep();
    endtask

    // output held off while input keeps coming, so the cache stalls
    task automatic test_output_stall();
        @(negedge aclk);
        holdoff_left = HOLDOFF_CYCLES;
        for (int i = 0; i < 20; i++)
            send_packet(pool_key[i % 6], pool_ind[i % 6], {$urandom, $urandom});
        send_sweep();
        wait_drained();
    endtask

    // mostly pooled flows so records hit, fill and age out
    task automatic test_random_traffic(input int count);
        int r;
        int k;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                idling_on = (n != 200);
                write_idle_limit($urandom_range(0, 15));
            end
            r = $urandom_range(0, 99);
            clock_now = clock_now + $urandom_range(0, 4);
            if (r < 2)
                clock_now = clock_now + $urandom;
            if (r < 9) begin
                send_sweep();
            end else if (r < 14) begin
                send_packet({$urandom, $urandom}, 8'($urandom), {$urandom, $urandom});
            end else begin
                k = $urandom_range(0, 39);
                send_packet(pool_key[k], pool_ind[k], {$urandom, $urandom});
            end
            if ($urandom_range(0, 99) < 3)
                wait_drained();
        end
        wait_drained();
    endtask

    // result checking
    always @(posedge aclk) begin
        flow_rec_t got;
        flow_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {kind_t'(m_tuser), m_tdata[539:0]};
            got.key = m_tdata[63:0];
            got.ind = m_tdata[71:64];
            got.label = m_tdata[91:72];
            got.src_hi = m_tdata[155:92];
            got.src_lo = m_tdata[219:156];
            got.dst_hi = m_tdata[283:220];
            got.dst_lo = m_tdata[347:284];
            got.value = m_tdata[411:348];
            got.packets = m_tdata[475:412];
            got.start = m_tdata[507:476];
            got.last = m_tdata[539:508];
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: kind %0d key %h", got.kind, got.key);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: kind %0d/%0d key %h/%h ind %h/%h label %h/%h",
                                 want.kind, got.kind, want.key, got.key, want.ind, got.ind,
                                 want.label, got.label);
                        $display("  src %h%h/%h%h dst %h%h/%h%h", want.src_hi,
                                 want.src_lo, got.src_hi, got.src_lo, want.dst_hi,
                                 want.dst_lo, got.dst_hi, got.dst_lo);
                        $display("  value %h/%h packets %h/%h start %h/%h end %h/%h",
                                 want.value, got.value, want.packets, got.packets,
                                 want.start, got.start, want.last, got.last);
                    end
                end
            end
            rx_gap = idling_on ? $urandom_range(0, 3) : 0;
        end
    end

    // output ready with random gaps and the long hold-off
    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        quiet_cycles = 0;
        holdoff_left = 0;
        rx_gap = 0;
        idling_on = 1'b1;
        idle_limit = DEFAULT_IDLE;
        clock_now = '0;
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            cache_used[e] = 1'b0;
            cache_rec[e] = '0;
        end
        for (int k = 0; k < 40; k++) begin
            pool_key[k] = (k < 20) ? 64'(k) : {$urandom, $urandom};
            pool_ind[k] = (k % 3 == 0) ? SUM_INDICATOR : 8'($urandom_range(0, 2));
        end
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_basic_records();
        test_table_full();
        test_idle_limit();
        test_output_stall();
        test_random_traffic(334);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/frc_pkg.sv
rtl/frc_ctrl.sv
rtl/frc_dpath.sv
rtl/flow_record_cache_with_idle_export.sv
bench/flow_record_cache_with_idle_export_tb.sv
